/* sv/smib_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smib_pkg
// Shared types, opcodes and constants of the integer bytecode unit.
// ----------------------------------------------------------------------------
package smib_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int LOCAL_COUNT = 256;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int LA_W        = $clog2(LOCAL_COUNT);
    localparam int QDEPTH      = 2;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_ICONST_M1 = 8'h02;
    localparam logic [7:0] OP_ICONST_ZERO = 8'h03;
    localparam logic [7:0] OP_ICONST_ONE  = 8'h04;
    localparam logic [7:0] OP_ICONST_5 = 8'h08;
    localparam logic [7:0] OP_BIPUSH   = 8'h10;
    localparam logic [7:0] OP_ILOAD    = 8'h15;
    localparam logic [7:0] OP_ILOAD_0  = 8'h1A;
    localparam logic [7:0] OP_ILOAD_3  = 8'h1D;
    localparam logic [7:0] OP_ISTORE   = 8'h36;
    localparam logic [7:0] OP_ISTORE_0 = 8'h3B;
    localparam logic [7:0] OP_ISTORE_3 = 8'h3E;
    localparam logic [7:0] OP_IADD     = 8'h60;
    localparam logic [7:0] OP_ISUB     = 8'h64;
    localparam logic [7:0] OP_IMUL     = 8'h68;
    localparam logic [7:0] OP_IDIV     = 8'h6C;
    localparam logic [7:0] OP_IREM     = 8'h70;
    localparam logic [7:0] OP_INEG     = 8'h74;
    localparam logic [7:0] OP_ISHL     = 8'h78;
    localparam logic [7:0] OP_ISHR     = 8'h7A;
    localparam logic [7:0] OP_IUSHR    = 8'h7C;
    localparam logic [7:0] OP_IAND     = 8'h7E;
    localparam logic [7:0] OP_IOR      = 8'h80;
    localparam logic [7:0] OP_IXOR     = 8'h82;
    localparam logic [7:0] OP_IINC     = 8'h84;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALTED  = 3'd1;
    localparam logic [2:0] ST_UNIMPL  = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_UNDER   = 3'd4;
    localparam logic [2:0] ST_OVER    = 3'd5;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_PUSH  = 3'd1,
        K_STORE = 3'd2,
        K_BIN   = 3'd3,
        K_NEG   = 3'd4,
        K_IINC  = 3'd5,
        K_BAD   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        PS_NONE  = 2'd0,
        PS_CONST = 2'd1,
        PS_LOCAL = 2'd2
    } psrc_t;

    typedef struct packed {
        kind_t       kind;
        psrc_t       psrc;
        logic [7:0]  op;
        logic [31:0] imm;
        logic [7:0]  lidx;
        logic [31:0] inc;
        logic [1:0]  len;
        logic [1:0]  pops;
        logic        pushes;
    } dec_t;

endpackage

/* sv/stack_machine_int_bytecode_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_int_bytecode_unit
// Integer bytecode execution unit with operand stack and local variables.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bytecode request: opcode and two raw operand bytes.
//   m_axis returns one status request per bytecode: next pc, top of stack,
//   stack count and status.
//   A two-entry decode queue sits between the front decoder and the executor.
//   Push, store, neg, iinc and nop pass S_IDLE, S_READ and S_OUT; binary
//   ops add S_EXEC and S_MUL, and idiv/irem also wait in the iterative divider.
//   The executor works on one bytecode at a time, around the registered-read
//   stack memory, and takes the next only after the result is accepted.
//   After reset the executor clears the 256-entry local file, one entry a
//   cycle; requests queue up in the meantime.
//   A stalled m_axis holds the result; the queue keeps taking requests
//   until full.
// ----------------------------------------------------------------------------
module stack_machine_int_bytecode_unit import smib_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // func, first_operand_byte, second_operand_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // next_pc, top_value, stack_count, status
);

    logic q_valid, q_pop;
    dec_t q_head;

    smib_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
    );

    smib_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
    );

endmodule

/* sv/smib_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smib_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module smib_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/smib_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smib_front
// Accepts bytecode requests, classifies them and feeds a short decode queue.
// ----------------------------------------------------------------------------
module smib_front import smib_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] in_data,
    output logic        q_valid,
    input  logic        q_pop,
    output dec_t        q_head
);

    dec_t          d;
    dec_t          q_reg [QDEPTH];
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [7:0]    op, b1, b2;
    logic          push;

    assign op = in_data[7:0];
    assign b1 = in_data[15:8];
    assign b2 = in_data[23:16];

    always_comb
    begin
        d        = '0;
        d.op     = op;
        d.kind   = K_NONE;
        d.psrc   = PS_NONE;
        d.len    = 2'd1;
        d.lidx   = b1;
        d.inc    = {{24{b2[7]}}, b2};
        if (op == OP_NOP)
        begin
            d.kind = K_NONE;
        end
        else if (op >= OP_ICONST_M1 && op <= OP_ICONST_5)
        begin
            d.kind = K_PUSH; d.pushes = 1'b1; d.psrc = PS_CONST;
            d.imm  = 32'(op) - 32'd3;
        end
        else if (op == OP_BIPUSH)
        begin
            d.kind = K_PUSH; d.pushes = 1'b1; d.psrc = PS_CONST;
            d.imm  = {{24{b1[7]}}, b1}; d.len = 2'd2;
        end
        else if (op == OP_ILOAD)
        begin
            d.kind = K_PUSH; d.pushes = 1'b1; d.psrc = PS_LOCAL; d.len = 2'd2;
        end
        else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3)
        begin
            d.kind = K_PUSH; d.pushes = 1'b1; d.psrc = PS_LOCAL;
            d.lidx = op - OP_ILOAD_0;
        end
        else if (op == OP_ISTORE)
        begin
            d.kind = K_STORE; d.pops = 2'd1; d.len = 2'd2;
        end
        else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3)
        begin
            d.kind = K_STORE; d.pops = 2'd1; d.lidx = op - OP_ISTORE_0;
        end
        else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL || op == OP_IDIV ||
                 op == OP_IREM || op == OP_ISHL || op == OP_ISHR || op == OP_IUSHR ||
                 op == OP_IAND || op == OP_IOR || op == OP_IXOR)
        begin
            d.kind = K_BIN; d.pops = 2'd2; d.pushes = 1'b1;
        end
        else if (op == OP_INEG)
        begin
            d.kind = K_NEG; d.pops = 2'd1; d.pushes = 1'b1;
        end
        else if (op == OP_IINC)
        begin
            d.kind = K_IINC; d.len = 2'd3;
        end
        else
        begin
            d.kind = K_BAD;
        end
    end

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* sv/smib_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smib_div
// Iterative signed 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smib_div import smib_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);

    logic [31:0] q_reg, q_next, d_reg, d_next;
    logic [32:0] r_reg, r_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next, qn_reg, qn_next, rn_reg, rn_next;
    logic [32:0] trial;

    assign trial = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};

    always_comb
    begin
        q_next = q_reg; d_next = d_reg; r_next = r_reg; n_next = n_reg;
        busy_next = busy_reg; qn_next = qn_reg; rn_next = rn_reg;
        if (start)
        begin
            q_next    = a[31] ? 32'd0 - a : a;
            d_next    = b[31] ? 32'd0 - b : b;
            r_next    = '0;
            n_next    = 6'd32;
            busy_next = 1'b1;
            qn_next   = a[31] ^ b[31];
            rn_next   = a[31];
        end
        else if (busy_reg)
        begin
            if (n_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (!trial[32])
                begin
                    r_next = trial;
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[31:0], q_reg[31]};
                    q_next = {q_reg[30:0], 1'b0};
                end
                n_next = n_reg - 6'd1;
            end
        end
    end

    assign done = busy_reg && (n_reg == 6'd0);
    assign quot = qn_reg ? 32'd0 - q_reg : q_reg;
    assign rem  = rn_reg ? 32'd0 - r_reg[31:0] : r_reg[31:0];

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        d_reg  <= d_next;
        r_reg  <= r_next;
        qn_reg <= qn_next;
        rn_reg <= rn_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= 6'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            n_reg    <= n_next;
            busy_reg <= busy_next;
        end
    end

endmodule

/* sv/smib_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smib_back
// Executes decoded bytecodes on the operand stack and local variable file.
// ----------------------------------------------------------------------------
module smib_back import smib_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  dec_t        q_head,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [55:0] out_data
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t            st_reg, st_next;
    dec_t              cur_reg, cur_next;
    logic [15:0]       pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [31:0]       top_reg, top_next;
    logic [31:0]       b_reg, b_next;
    logic [31:0]       m_reg, m_next;
    logic [2:0]        status_reg, status_next;
    logic [LA_W:0]     clr_reg, clr_next;

    logic              s_we;
    logic [SA_W-1:0]   s_waddr, s_raddr;
    logic [31:0]       s_wdata, s_rdata;
    logic              l_we;
    logic [LA_W-1:0]   l_waddr, l_raddr;
    logic [31:0]       l_wdata, l_rdata;
    logic              div_start, div_done;
    logic [31:0]       div_q, div_r;
    logic              lidx_ok;
    logic [31:0]       a_val, res;

    smib_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    smib_ram #(.WIDTH(32), .DEPTH(LOCAL_COUNT)) u_locals (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    smib_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .a(a_val), .b(b_reg),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    assign lidx_ok = ({1'b0, cur_reg.lidx} < 9'(LOCAL_COUNT));
    assign a_val   = s_rdata;

    always_comb
    begin
        case (cur_reg.op)
            OP_IADD:  res = a_val + b_reg;
            OP_ISUB:  res = a_val - b_reg;
            OP_ISHL:  res = a_val << b_reg[4:0];
            OP_ISHR:  res = 32'($signed(a_val) >>> b_reg[4:0]);
            OP_IUSHR: res = a_val >> b_reg[4:0];
            OP_IAND:  res = a_val & b_reg;
            OP_IOR:   res = a_val | b_reg;
            default:  res = a_val ^ b_reg;
        endcase
    end

    always_comb
    begin
        st_next = st_reg; cur_next = cur_reg; pc_next = pc_reg; halt_next = halt_reg;
        sp_next = sp_reg; top_next = top_reg; b_next = b_reg; m_next = m_reg;
        status_next = status_reg; clr_next = clr_reg;
        q_pop = 1'b0; s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        s_raddr = SA_W'(sp_reg - SP_W'(2));
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = cur_reg.lidx[LA_W-1:0];
        div_start = 1'b0;
        case (st_reg)
            S_CLEAR:
            begin
                l_we    = 1'b1;
                l_waddr = clr_reg[LA_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (LA_W+1)'(LOCAL_COUNT - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    st_next  = S_READ;
                    if (halt_reg)
                    begin
                        status_next = ST_HALTED;
                        st_next     = S_OUT;
                    end
                    else if (q_head.kind == K_BAD)
                    begin
                        status_next = ST_UNIMPL; halt_next = 1'b1; st_next = S_OUT;
                    end
                    else if (sp_reg < SP_W'(q_head.pops))
                    begin
                        status_next = ST_UNDER; halt_next = 1'b1; st_next = S_OUT;
                    end
                    else if (q_head.pushes && q_head.pops == 2'd0 &&
                             sp_reg == SP_W'(STACK_DEPTH))
                    begin
                        status_next = ST_OVER; halt_next = 1'b1; st_next = S_OUT;
                    end
                    l_raddr = q_head.lidx[LA_W-1:0];
                end
            end
            S_READ:
            begin
                st_next = S_EXEC;
                b_next  = top_reg;
                case (cur_reg.kind)
                    K_PUSH:
                    begin
                        top_next = (cur_reg.psrc == PS_CONST) ? cur_reg.imm :
                                   (lidx_ok ? l_rdata : 32'd0);
                        s_we    = 1'b1;
                        s_waddr = SA_W'(sp_reg);
                        s_wdata = top_next;
                        sp_next = sp_reg + 1'b1;
                        pc_next = pc_reg + 16'(cur_reg.len);
                        status_next = ST_OK;
                        st_next = S_OUT;
                    end
                    K_STORE:
                    begin
                        l_we    = lidx_ok;
                        l_waddr = cur_reg.lidx[LA_W-1:0];
                        l_wdata = top_reg;
                        top_next = s_rdata;
                        sp_next = sp_reg - 1'b1;
                        pc_next = pc_reg + 16'(cur_reg.len);
                        status_next = ST_OK;
                        st_next = S_OUT;
                    end
                    K_NEG:
                    begin
                        top_next = 32'd0 - top_reg;
                        s_we    = 1'b1;
                        s_waddr = SA_W'(sp_reg - 1'b1);
                        s_wdata = top_next;
                        pc_next = pc_reg + 16'(cur_reg.len);
                        status_next = ST_OK;
                        st_next = S_OUT;
                    end
                    K_IINC:
                    begin
                        l_we    = lidx_ok;
                        l_waddr = cur_reg.lidx[LA_W-1:0];
                        l_wdata = l_rdata + cur_reg.inc;
                        pc_next = pc_reg + 16'(cur_reg.len);
                        status_next = ST_OK;
                        st_next = S_OUT;
                    end
                    K_BIN:
                    begin
                        st_next = S_EXEC;
                    end
                    default:
                    begin
                        pc_next = pc_reg + 16'(cur_reg.len);
                        status_next = ST_OK;
                        st_next = S_OUT;
                    end
                endcase
            end
            S_EXEC:
            begin
                if ((cur_reg.op == OP_IDIV || cur_reg.op == OP_IREM) && b_reg == 32'd0)
                begin
                    status_next = ST_DIVZERO; halt_next = 1'b1; st_next = S_OUT;
                end
                else if (cur_reg.op == OP_IDIV || cur_reg.op == OP_IREM)
                begin
                    div_start = 1'b1;
                    st_next   = S_DIV;
                end
                else if (cur_reg.op == OP_IMUL)
                begin
                    m_next  = a_val * b_reg;
                    st_next = S_MUL;
                end
                else
                begin
                    m_next  = res;
                    st_next = S_MUL;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    m_next  = (cur_reg.op == OP_IDIV) ? div_q : div_r;
                    st_next = S_MUL;
                end
            end
            S_MUL:
            begin
                top_next = m_reg;
                s_we     = 1'b1;
                s_waddr  = SA_W'(sp_reg - SP_W'(2));
                s_wdata  = m_reg;
                sp_next  = sp_reg - 1'b1;
                pc_next  = pc_reg + 16'(cur_reg.len);
                status_next = ST_OK;
                st_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = (st_reg == S_OUT);
    assign out_data  = {status_reg, 5'(sp_reg),
                        (sp_reg == '0) ? 32'd0 : top_reg, pc_reg};

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        top_reg <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_CLEAR;
            pc_reg     <= '0;
            halt_reg   <= 1'b0;
            sp_reg     <= '0;
            status_reg <= ST_OK;
            clr_reg    <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            pc_reg     <= pc_next;
            halt_reg   <= halt_next;
            sp_reg     <= sp_next;
            status_reg <= status_next;
            clr_reg    <= clr_next;
        end
    end

endmodule

/* bench/tb_stack_machine_int_bytecode_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_machine_int_bytecode_unit
// Self-checking bench for the integer bytecode unit: a directed opening,
// about 2000 random well-formed bytecodes kept clear of faults, then one fault
// picked at random followed by requests that must come back as halted.
// Results are predicted at input acceptance and compared field by field.
// ----------------------------------------------------------------------------
module tb_stack_machine_int_bytecode_unit;
    import smib_pkg::*;

    typedef struct packed {
        logic        drain;
        logic [7:0]  b2;
        logic [7:0]  b1;
        logic [7:0]  func;
    } bc_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  count;
        logic [31:0] top;
        logic [15:0] pc;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    stack_machine_int_bytecode_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bc_req_t     pending_reqs[$];
    status_t     expected_status[$];
    int          err_cnt;
    int          result_cnt;
    int          gen_depth;
    int          fault_kind;
    bit          gen_done;

    // predictor state
    logic [15:0] pr_pc;
    logic        pr_halted;
    int          pr_depth;
    logic [31:0] pr_stack[STACK_DEPTH];
    logic [31:0] pr_locals[LOCAL_COUNT];

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic status_t snap(logic [2:0] st);
        status_t r;
        r.pc     = pr_pc;
        r.top    = (pr_depth != 0) ? pr_stack[pr_depth - 1] : 32'd0;
        r.count  = pr_depth[4:0];
        r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] sx8(logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic status_t execute_bytecode(logic [7:0] op, logic [7:0] b1,
                                                 logic [7:0] b2);
        int          pops;
        int          pushes;
        int          len;
        kind_t       k;
        logic [31:0] pv;
        logic [7:0]  idx;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        pops = 0;
        pushes = 0;
        len = 1;
        pv = '0;
        idx = b1;
        r = '0;
        k = K_NONE;
        if (pr_halted)
            return snap(ST_HALTED);
        if (op == OP_NOP)
            k = K_NONE;
        else if (op >= OP_ICONST_M1 && op <= OP_ICONST_5)
        begin
            k = K_PUSH; pushes = 1; pv = {24'd0, op} - 32'd3;
        end
        else if (op == OP_BIPUSH)
        begin
            k = K_PUSH; pushes = 1; pv = sx8(b1); len = 2;
        end
        else if (op == OP_ILOAD)
        begin
            k = K_PUSH; pushes = 1; pv = pr_locals[b1]; len = 2;
        end
        else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3)
        begin
            k = K_PUSH; pushes = 1; pv = pr_locals[op - OP_ILOAD_0];
        end
        else if (op == OP_ISTORE)
        begin
            k = K_STORE; pops = 1; len = 2;
        end
        else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3)
        begin
            k = K_STORE; pops = 1; idx = op - OP_ISTORE_0;
        end
        else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL || op == OP_IDIV ||
                 op == OP_IREM || op == OP_ISHL || op == OP_ISHR || op == OP_IUSHR ||
                 op == OP_IAND || op == OP_IOR || op == OP_IXOR)
        begin
            k = K_BIN; pops = 2; pushes = 1;
        end
        else if (op == OP_INEG)
        begin
            k = K_NEG; pops = 1; pushes = 1;
        end
        else if (op == OP_IINC)
        begin
            k = K_IINC; len = 3;
        end
        else
        begin
            pr_halted = 1'b1;
            return snap(ST_UNIMPL);
        end
        if (pr_depth < pops)
        begin
            pr_halted = 1'b1;
            return snap(ST_UNDER);
        end
        if (pr_depth - pops + pushes > STACK_DEPTH)
        begin
            pr_halted = 1'b1;
            return snap(ST_OVER);
        end
        case (k)
            K_PUSH:
            begin
                pr_stack[pr_depth] = pv;
                pr_depth++;
            end
            K_STORE:
            begin
                pr_depth--;
                pr_locals[idx] = pr_stack[pr_depth];
            end
            K_BIN:
            begin
                b = pr_stack[pr_depth - 1];
                a = pr_stack[pr_depth - 2];
                if ((op == OP_IDIV || op == OP_IREM) && b == 32'd0)
                begin
                    pr_halted = 1'b1;
                    return snap(ST_DIVZERO);
                end
                case (op)
                    OP_IADD:  r = a + b;
                    OP_ISUB:  r = a - b;
                    OP_IMUL:  r = a * b;
                    OP_IDIV:
                    begin
                        r = mag(a) / mag(b);
                        if (a[31] ^ b[31])
                            r = 32'd0 - r;
                    end
                    OP_IREM:
                    begin
                        r = mag(a) % mag(b);
                        if (a[31])
                            r = 32'd0 - r;
                    end
                    OP_ISHL:  r = a << b[4:0];
                    OP_ISHR:  r = $signed(a) >>> b[4:0];
                    OP_IUSHR: r = a >> b[4:0];
                    OP_IAND:  r = a & b;
                    OP_IOR:   r = a | b;
                    default:  r = a ^ b;
                endcase
                pr_depth--;
                pr_stack[pr_depth - 1] = r;
            end
            K_NEG:
                pr_stack[pr_depth - 1] = 32'd0 - pr_stack[pr_depth - 1];
            K_IINC:
                pr_locals[b1] = pr_locals[b1] + sx8(b2);
            default: ;
        endcase
        pr_pc = pr_pc + len[15:0];
        return snap(ST_OK);
    endfunction

    // ---------------- stimulus generation ----------------
    task automatic add_req(logic [7:0] f, logic [7:0] b1, logic [7:0] b2, bit drain = 0);
        bc_req_t q;
        q.func = f;
        q.b1 = b1;
        q.b2 = b2;
        q.drain = drain;
        pending_reqs.push_back(q);
    endtask

    // pushes and pops tracked on gen_depth so the random part stays legal
    task automatic gen_push(logic [7:0] f, logic [7:0] b1);
        add_req(f, b1, 8'($urandom));
        gen_depth++;
    endtask

    task automatic gen_pop(logic [7:0] f, logic [7:0] b1, int n);
        add_req(f, b1, 8'($urandom));
        gen_depth -= n;
    endtask

    function automatic logic [7:0] pick_binop();
        logic [7:0] ops[9];
        ops = '{OP_IADD, OP_ISUB, OP_IMUL, OP_ISHL, OP_ISHR, OP_IUSHR,
                OP_IAND, OP_IOR, OP_IXOR};
        return ops[$urandom_range(0, 8)];
    endfunction

    task automatic gen_random_one();
        int          c;
        logic [7:0]  v;
        c = $urandom_range(0, 99);
        if (c < 30 && gen_depth < STACK_DEPTH)
        begin
            case ($urandom_range(0, 3))
                0: gen_push(8'($urandom_range(OP_ICONST_M1, OP_ICONST_5)), 8'($urandom));
                1: gen_push(OP_BIPUSH, 8'($urandom));
                2: gen_push(OP_ILOAD, 8'($urandom));
                default: gen_push(8'($urandom_range(OP_ILOAD_0, OP_ILOAD_3)), 8'($urandom));
            endcase
        end
        else if (c < 60 && gen_depth >= 2)
            gen_pop(pick_binop(), 8'($urandom), 1);
        else if (c < 70 && gen_depth >= 1 && gen_depth < STACK_DEPTH)
        begin
            v = 8'($urandom);
            if (v == 8'd0)
                v = 8'd1;
            gen_push(OP_BIPUSH, v);
            gen_pop(($urandom_range(0, 1) != 0) ? OP_IDIV : OP_IREM, 8'($urandom), 1);
        end
        else if (c < 82 && gen_depth >= 1)
        begin
            if ($urandom_range(0, 1) != 0)
                gen_pop(OP_ISTORE, 8'($urandom), 1);
            else
                gen_pop(8'($urandom_range(OP_ISTORE_0, OP_ISTORE_3)), 8'($urandom), 1);
        end
        else if (c < 87 && gen_depth >= 1)
            gen_pop(OP_INEG, 8'($urandom), 0);
        else if (c < 95)
            gen_pop(OP_IINC, 8'($urandom), 0);
        else
            gen_pop(OP_NOP, 8'($urandom), 0);
    endtask

    function automatic bit is_impl(logic [7:0] f);
        return f == OP_NOP || (f >= OP_ICONST_M1 && f <= OP_ICONST_5) || f == OP_BIPUSH ||
               f == OP_ILOAD || (f >= OP_ILOAD_0 && f <= OP_ILOAD_3) || f == OP_ISTORE ||
               (f >= OP_ISTORE_0 && f <= OP_ISTORE_3) || f == OP_IADD || f == OP_ISUB ||
               f == OP_IMUL || f == OP_IDIV || f == OP_IREM || f == OP_INEG ||
               f == OP_ISHL || f == OP_ISHR || f == OP_IUSHR || f == OP_IAND ||
               f == OP_IOR || f == OP_IXOR || f == OP_IINC;
    endfunction

    task automatic gen_fault();
        logic [7:0] f;
        fault_kind = $urandom_range(0, 3);
        case (fault_kind)
            0:
            begin
                f = 8'($urandom);
                while (is_impl(f))
                    f = 8'($urandom);
                add_req(f, 8'($urandom), 8'($urandom), 1'b1);
            end
            1:
            begin
                if (gen_depth == STACK_DEPTH)
                    gen_pop(OP_ISTORE_0 + 8'd1, 8'd0, 1);
                if (gen_depth == 0)
                    gen_push(OP_BIPUSH, 8'h80);
                gen_push(OP_ICONST_ZERO, 8'd0);
                add_req(($urandom_range(0, 1) != 0) ? OP_IDIV : OP_IREM, 8'd0, 8'd0, 1'b1);
            end
            2:
            begin
                while (gen_depth > 0)
                    gen_pop(OP_ISTORE_0 + 8'd2, 8'd0, 1);
                add_req(($urandom_range(0, 1) != 0) ? OP_INEG : OP_IADD, 8'd0, 8'd0, 1'b1);
            end
            default:
            begin
                while (gen_depth < STACK_DEPTH)
                    gen_push(OP_BIPUSH, 8'($urandom));
                add_req(OP_ICONST_5, 8'd0, 8'd0, 1'b1);
            end
        endcase
        // everything after the fault must report halted
        repeat (12)
            add_req(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // ---------------- driver ----------------
    bit      in_acc;
    bit      drv_busy;
    bc_req_t drv_cur;
    int      drv_gap;

    always @(posedge clk)
    begin
        in_acc <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_status.push_back(execute_bytecode(s_axis_tdata[7:0],
                                      s_axis_tdata[15:8], s_axis_tdata[23:16]));
    end

    function automatic int draw_gap();
        int c;
        c = $urandom_range(0, 99);
        if (c < 65)
            return 0;
        else if (c < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (drv_busy && in_acc)
                drv_busy = 1'b0;
            if (!drv_busy)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && expected_status.size() != 0))
                begin
                    drv_cur = pending_reqs.pop_front();
                    drv_busy = 1'b1;
                    drv_gap = draw_gap();
                end
            end
            s_axis_tvalid <= drv_busy;
            s_axis_tdata  <= {drv_cur.b2, drv_cur.b1, drv_cur.func};
        end
    end

    // ---------------- monitor ----------------
    int hold_cnt;
    bit long_hold_done;

    always @(posedge clk)
    begin
        status_t got;
        status_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            result_cnt++;
            if (expected_status.size() == 0)
            begin
                $error("result with nothing expected: %h", m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                exp_r = expected_status.pop_front();
                if (got.pc !== exp_r.pc)
                begin
                    $error("next_pc expected %h actual %h", exp_r.pc, got.pc);
                    err_cnt++;
                end
                if (got.top !== exp_r.top)
                begin
                    $error("top_value expected %h actual %h", exp_r.top, got.top);
                    err_cnt++;
                end
                if (got.count !== exp_r.count)
                begin
                    $error("stack_count expected %0d actual %0d", exp_r.count, got.count);
                    err_cnt++;
                end
                if (got.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, got.status);
                    err_cnt++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && result_cnt >= 300)
            begin
                long_hold_done = 1'b1;
                hold_cnt = 400;
            end
            else if (hold_cnt == 0 && ($urandom_range(0, 99) < 8))
                hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= (result_cnt / 200) % 3 != 1 ||
                                 ($urandom_range(0, 3) != 0);
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rst_n         = 1'b0;
        err_cnt = 0;
        result_cnt = 0;
        gen_depth = 0;
        hold_cnt = 0;
        drv_gap = 0;
        drv_busy = 1'b0;
        drv_cur = '0;
        pr_pc = '0;
        pr_halted = 1'b0;
        pr_depth = 0;
        foreach (pr_stack[i])
            pr_stack[i] = '0;
        foreach (pr_locals[i])
            pr_locals[i] = '0;

        // directed opening
        for (int v = OP_ICONST_M1; v <= OP_ICONST_5; v++)
            gen_push(8'(v), 8'hFF);
        gen_push(OP_BIPUSH, 8'h7F);
        gen_push(OP_BIPUSH, 8'h80);
        gen_pop(OP_ISTORE, 8'hFF, 1);
        gen_pop(OP_ISTORE_3, 8'h00, 1);
        add_req(OP_IINC, 8'hFF, 8'h80);
        add_req(OP_IINC, 8'h00, 8'h7F);
        gen_push(OP_ILOAD, 8'hFF);
        gen_push(OP_ILOAD_3, 8'h00);
        gen_push(OP_ILOAD_0, 8'h00);
        add_req(OP_NOP, 8'h00, 8'hFF);
        // most negative value over minus one, quotient then remainder
        gen_push(OP_ICONST_ONE, 8'd0);
        gen_push(OP_BIPUSH, 8'd31);
        gen_pop(OP_ISHL, 8'd0, 1);
        gen_pop(OP_ISTORE_0 + 8'd1, 8'd0, 1);
        gen_push(OP_ILOAD_0 + 8'd1, 8'd0);
        gen_push(OP_ICONST_M1, 8'd0);
        gen_pop(OP_IDIV, 8'd0, 1);
        gen_push(OP_ILOAD_0 + 8'd1, 8'd0);
        gen_push(OP_ICONST_M1, 8'd0);
        gen_pop(OP_IREM, 8'd0, 1);
        gen_pop(OP_INEG, 8'd0, 0);
        gen_pop(OP_ISHR, 8'd0, 1);
        gen_pop(OP_IUSHR, 8'd0, 1);

        while (pending_reqs.size() < 1000)
            gen_random_one();
        add_req(OP_NOP, 8'($urandom), 8'($urandom), 1'b1);
        while (pending_reqs.size() < 2050)
            gen_random_one();
        gen_fault();
        gen_done = 1'b1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !drv_busy);
        wait (expected_status.size() == 0);
        repeat (60) @(posedge clk);
        $display("checked %0d results over random stack code, fault case %0d at the end",
                 result_cnt, fault_kind);
        if (err_cnt == 0 && expected_status.size() == 0)
            $display("tb_stack_machine_int_bytecode_unit: done, clean");
        else
            $display("tb_stack_machine_int_bytecode_unit: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout after %0d results", result_cnt);
        $display("tb_stack_machine_int_bytecode_unit: done, errors");
        $finish;
    end

endmodule
